// ===== hdl/indoor_bike_record_parser_defines.svh =====
// Assertion macros shared by the indoor bike record parser checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef INDOOR_BIKE_RECORD_PARSER_DEFINES_SVH
`define INDOOR_BIKE_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== hdl/ibrp_pkg.sv =====
// Package for the indoor bike record parser: item types, status codes,
// and the field presence/length tables. No dependencies.
`timescale 1ns / 1ps

package ibrp_pkg;

	localparam int BYTE_W     = 8;
	localparam int FLAGS_W    = 16;                 // flags word as sent
	localparam int FLAG_HI    = 12;                 // highest flag bit in use
	localparam int FLAG_W     = FLAG_HI + 1;        // flag bits kept
	localparam int VALUE_W    = 24;
	localparam int NUM_FIELDS = 15;

	localparam logic [3:0] NO_FIELD = 4'd15;
	localparam logic [1:0] HDR_DONE = 2'd2;

	localparam logic [1:0] ST_FIELD = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;
	localparam logic [1:0] ST_TRAIL = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              packet_end;
	} rec_item_t;

	typedef struct packed {
		logic [3:0]         field_id;
		logic [VALUE_W-1:0] field_value;
		logic [1:0]         status;
		logic               last_of_packet;
	} fld_item_t;

	// Flag bit that controls each field.
	function automatic logic [3:0] flag_bit_of(input logic [3:0] id);
		logic [3:0] b;
		case (id)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: b = id;
			4'd9, 4'd10:                                         b = 4'd8;
			default:                                             b = id - 4'd2;
		endcase
		return b;
	endfunction

	// Field length in bytes.
	function automatic logic [1:0] field_len(input logic [3:0] id);
		logic [1:0] n;
		case (id)
			4'd4:                n = 2'd3;
			4'd10, 4'd11, 4'd12: n = 2'd1;
			default:             n = 2'd2;
		endcase
		return n;
	endfunction

	// A field is present when its flag bit is set; instant speed (field 0) is present when its flag bit is clear.
	function automatic logic field_present(input logic [FLAG_W-1:0] flags,
		input logic [3:0] id);
		logic bitval;
		bitval = flags[flag_bit_of(id)];
		return (id == 4'd0) ? !bitval : bitval;
	endfunction

endpackage

// ===== hdl/ibrp_next_field.sv =====
// Priority encoder: lowest present field at or after a start id.
// Depends on ibrp_pkg.
`timescale 1ns / 1ps

module ibrp_next_field (
	input  logic [ibrp_pkg::FLAG_W-1:0] flags,
	input  logic [3:0]                  start,
	output logic [3:0]                  id,
	output logic                        none
);
	import ibrp_pkg::*;

	always_comb begin
		id   = NO_FIELD;
		none = 1'b1;
		// scan downward so the lowest match wins
		for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
			if (4'(i) >= start && field_present(flags, 4'(i))) begin
				id   = 4'(i);
				none = 1'b0;
			end
		end
	end

endmodule

// ===== hdl/ibrp_core.sv =====
// Parser state and per-byte result logic for the indoor bike record parser.
// Depends on ibrp_pkg and ibrp_next_field.
`timescale 1ns / 1ps

module ibrp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  ibrp_pkg::rec_item_t item,
	output logic                res_valid,
	output ibrp_pkg::fld_item_t res
);
	import ibrp_pkg::*;

	logic [FLAG_W-1:0]  flags_q, flags_n, sel_flags;
	logic [1:0]         hdr_q, hdr_n;
	logic [3:0]         fld_q, fld_n, sel_start, nxt_id;
	logic               nxt_none;
	logic [1:0]         bif_q, bif_n;
	logic [VALUE_W-1:0] acc_q, acc_n;
	logic               done_q, done_n;
	logic               clear;

	assign sel_flags = (hdr_q == HDR_DONE) ? flags_q :
		(hdr_q == 2'd0) ? {{(FLAG_W - BYTE_W){1'b0}}, item.byte_in} :
		{item.byte_in[FLAG_W-BYTE_W-1:0], flags_q[BYTE_W-1:0]};
	assign sel_start = (hdr_q == HDR_DONE) ? fld_q + 4'd1 : 4'd0;

	ibrp_next_field u_next (
		.flags (sel_flags),
		.start (sel_start),
		.id    (nxt_id),
		.none  (nxt_none)
	);

	always_comb begin
		flags_n   = flags_q;
		hdr_n     = hdr_q;
		fld_n     = fld_q;
		bif_n     = bif_q;
		acc_n     = acc_q;
		done_n    = done_q;
		clear     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		if (step) begin
			if (hdr_q != HDR_DONE) begin
				flags_n = sel_flags;
				hdr_n   = hdr_q + 2'd1;
				if (hdr_n == HDR_DONE) begin
					if (nxt_none) done_n = 1'b1;
					else          fld_n  = nxt_id;
				end
				if (item.packet_end) begin
					res_valid          = 1'b1;
					res.status         = (hdr_n == HDR_DONE && done_n) ? ST_DONE : ST_TRUNC;
					res.last_of_packet = 1'b1;
					clear              = 1'b1;
				end
			end else if (done_q) begin
				// trailing bytes: drop, close on packet end
				if (item.packet_end) begin
					res_valid          = 1'b1;
					res.status         = ST_TRAIL;
					res.last_of_packet = 1'b1;
					clear              = 1'b1;
				end
			end else begin
				case (bif_q)
					2'd0:    acc_n = acc_q | {16'b0, item.byte_in};
					2'd1:    acc_n = acc_q | {8'b0, item.byte_in, 8'b0};
					default: acc_n = acc_q | {item.byte_in, 16'b0};
				endcase
				bif_n = bif_q + 2'd1;
				if (bif_n >= field_len(fld_q)) begin
					res_valid       = 1'b1;
					res.field_id    = fld_q;
					res.field_value = acc_n;
					res.status      = ST_FIELD;
					acc_n           = '0;
					bif_n           = 2'd0;
					if (nxt_none) done_n = 1'b1;
					else          fld_n  = nxt_id;
					if (item.packet_end) begin
						clear              = 1'b1;
						res.last_of_packet = 1'b1;
						// a field still expected: record cut short
						if (!done_n) begin
							res.field_id    = 4'd0;
							res.field_value = '0;
							res.status      = ST_TRUNC;
						end
					end
				end else if (item.packet_end) begin
					res_valid          = 1'b1;
					res.status         = ST_TRUNC;
					res.last_of_packet = 1'b1;
					clear              = 1'b1;
				end
			end
			if (clear) begin
				flags_n = '0;
				hdr_n   = 2'd0;
				fld_n   = 4'd0;
				bif_n   = 2'd0;
				acc_n   = '0;
				done_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			hdr_q   <= 2'd0;
			fld_q   <= 4'd0;
			bif_q   <= 2'd0;
			acc_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			flags_q <= flags_n;
			hdr_q   <= hdr_n;
			fld_q   <= fld_n;
			bif_q   <= bif_n;
			acc_q   <= acc_n;
			done_q  <= done_n;
		end
	end

endmodule

// ===== hdl/indoor_bike_record_parser.sv =====
// Indoor bike record parser: one record byte per item, at most one field result per item.
// Each item passes the input register, the parser logic and the result register
// on its way to fld_item.
// Throughput: 1 item per cycle; the parser finishes each byte in one step, and
// rec_stall rises only when both stages hold items and fld_stall is high.
// Reset clears the record state and valid bits; the next byte starts a record.
`timescale 1ns / 1ps

module indoor_bike_record_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_stall,
	input  ibrp_pkg::rec_item_t rec_item,
	output logic                fld_valid,
	input  logic                fld_stall,
	output ibrp_pkg::fld_item_t fld_item
);
	import ibrp_pkg::*;

	rec_item_t item_s1;
	logic      valid_s1;
	fld_item_t item_s2;
	logic      valid_s2;
	logic      advance;
	logic      core_valid;
	fld_item_t core_res;

	// the result register frees when empty or taken this cycle
	assign advance   = !valid_s2 || !fld_stall;
	assign rec_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_valid && !rec_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid && !rec_stall) begin
			item_s1 <= rec_item;
		end
	end

	ibrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.item      (item_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2 <= core_res;
		end
	end

	assign fld_valid = valid_s2;
	assign fld_item  = item_s2;

endmodule

// ===== hdl/ibrp_checker.sv =====
// Port-level checks for the indoor bike record parser, bound to the top level.
// Depends on ibrp_pkg and indoor_bike_record_parser_defines.svh.
`timescale 1ns / 1ps
`include "indoor_bike_record_parser_defines.svh"

module ibrp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rec_valid,
	input logic                rec_stall,
	input ibrp_pkg::rec_item_t rec_item,
	input logic                fld_valid,
	input logic                fld_stall,
	input ibrp_pkg::fld_item_t fld_item
);
	import ibrp_pkg::*;

	`IBRP_ASSERT_NEXT(a_in_hold, clk, arst_n, rec_valid && rec_stall, rec_valid && $stable(rec_item))
	`IBRP_ASSERT_NEXT(a_out_hold, clk, arst_n, fld_valid && fld_stall, fld_valid && $stable(fld_item))
	`IBRP_ASSERT_IMPLY(a_close_zero, clk, arst_n, fld_valid && fld_item.status != ST_FIELD, fld_item.field_id == 4'd0 && fld_item.field_value == '0 && fld_item.last_of_packet)
	`IBRP_ASSERT_IMPLY(a_field_id, clk, arst_n, fld_valid && fld_item.status == ST_FIELD, fld_item.field_id != NO_FIELD)
	`IBRP_ASSERT_IMPLY(a_no_stall_empty, clk, arst_n, !fld_valid, !rec_stall)

endmodule

bind indoor_bike_record_parser ibrp_checker u_ibrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec_valid),
	.rec_stall (rec_stall),
	.rec_item  (rec_item),
	.fld_valid (fld_valid),
	.fld_stall (fld_stall),
	.fld_item  (fld_item)
);
